/* design/spl_pkg.sv */
// ----------------------------------------------------------------------------
// spl_pkg
// Shared types and constants for the sparse pixel lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package spl_pkg;

  localparam int OP_W       = 2;
  localparam int ROW_W      = 9;
  localparam int COL_W      = 10;
  localparam int SLOT_W     = 14;
  localparam int PTR_W      = 15;
  localparam int LABEL_W    = 8;
  localparam int DEPTH_W    = 16;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);

  typedef enum logic [OP_W-1:0] {
    OP_ROW_END = 2'd0,
    OP_ENTRY   = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_NONE    = 2'd3
  } spl_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_MISSING_LABEL = 2'd2,
    REG_MISSING_DEPTH = 2'd3
  } spl_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW_END,
    S_ROW_START,
    S_SEARCH,
    S_CHECK,
    S_RESULT
  } spl_state_e;

  typedef struct packed {
    logic [WIDTH_W-1:0]  image_width;
    logic [HEIGHT_W-1:0] image_height;
    logic [LABEL_W-1:0]  missing_label;
    logic [DEPTH_W-1:0]  missing_depth;
  } spl_cfg_t;

endpackage

`default_nettype wire

/* design/spl_req_if.sv */
// ----------------------------------------------------------------------------
// spl_req_if
// Request channel: operation plus row, column and entry payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface spl_req_if import spl_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    column;
  logic [SLOT_W-1:0]   entry_slot;
  logic [PTR_W-1:0]    row_end;
  logic [LABEL_W-1:0]  label_in;
  logic [DEPTH_W-1:0]  depth_in;

  modport source (output valid, operation, row, column, entry_slot, row_end,
                  label_in, depth_in, input ready);
  modport sink   (input valid, operation, row, column, entry_slot, row_end,
                  label_in, depth_in, output ready);
endinterface

`default_nettype wire

/* design/spl_rsp_if.sv */
// ----------------------------------------------------------------------------
// spl_rsp_if
// Result channel: lookup outcome.
// ----------------------------------------------------------------------------
`default_nettype none

interface spl_rsp_if import spl_pkg::*;;
  logic                valid;
  logic                ready;
  logic                found;
  logic [SLOT_W-1:0]   entry_position;
  logic [LABEL_W-1:0]  label_out;
  logic [DEPTH_W-1:0]  depth_out;

  modport source (output valid, found, entry_position, label_out, depth_out,
                  input ready);
  modport sink   (input valid, found, entry_position, label_out, depth_out,
                  output ready);
endinterface

`default_nettype wire

/* design/spl_cfg_if.sv */
// ----------------------------------------------------------------------------
// spl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface spl_cfg_if import spl_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/sparse_pixel_lookup.sv */
// ----------------------------------------------------------------------------
// sparse_pixel_lookup
// Sparse labelled depth image in compressed-row form with pixel lookup.
// ----------------------------------------------------------------------------
// Requests write a row end pointer, write an entry (column, label, depth) or
// look up a pixel. Writes are performed as they are accepted in the idle
// state. A lookup whose coordinates fall outside the configured image goes
// straight to the result state; otherwise it reads the row end and row start
// pointers from the row memory, then runs a lower-bound search over the
// row's columns in the entry memory, one probe per cycle as each registered
// read returns, followed by a check state for the final slot and a result
// state that loads the output register. An empty row skips the search. One
// request is in work at a time; a new request is taken while the previous
// result still waits in the output register. Neither memory is cleared:
// every slot or row pointer must be written before a lookup reaches it.
`default_nettype none

module sparse_pixel_lookup import spl_pkg::*; #(
  parameter int MAX_ROWS    = 512,
  parameter int MAX_ENTRIES = 16384,
  parameter int LABEL_BITS  = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  spl_cfg_if.sink   cfg,
  spl_req_if.sink   req,
  spl_rsp_if.source rsp
);

  spl_cfg_t regs;

  spl_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  spl_engine #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_ENTRIES (MAX_ENTRIES),
    .LABEL_BITS  (LABEL_BITS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .req  (req),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire

/* design/spl_ram.sv */
// ----------------------------------------------------------------------------
// spl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module spl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/spl_cfg_regs.sv */
// ----------------------------------------------------------------------------
// spl_cfg_regs
// Configuration register file: image size and defaults for missing pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module spl_cfg_regs import spl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  spl_cfg_if.sink   cfg,
  output spl_cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.image_width   <= WIDTH_RST;
      regs.image_height  <= HEIGHT_RST;
      regs.missing_label <= '0;
      regs.missing_depth <= '0;
    end else if (cfg.valid) begin
      unique case (spl_reg_e'(cfg.index))
        REG_IMAGE_WIDTH:   regs.image_width   <= cfg.data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:  regs.image_height  <= cfg.data[HEIGHT_W-1:0];
        REG_MISSING_LABEL: regs.missing_label <= cfg.data[LABEL_W-1:0];
        REG_MISSING_DEPTH: regs.missing_depth <= cfg.data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/spl_engine.sv */
// ----------------------------------------------------------------------------
// spl_engine
// Row pointer and entry memories, lower-bound search sequencer, output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module spl_engine import spl_pkg::*; #(
  parameter int MAX_ROWS    = 512,
  parameter int MAX_ENTRIES = 16384,
  parameter int LABEL_BITS  = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire spl_cfg_t regs,
  spl_req_if.sink       req,
  spl_rsp_if.source     rsp
);

  localparam int RAW = $clog2(MAX_ROWS);
  localparam int EAW = $clog2(MAX_ENTRIES);
  localparam int LBW = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
  localparam int EW  = COL_W + LBW + DEPTH_W;
  localparam int SAT = (MAX_ENTRIES < (1 << PTR_W)) ? MAX_ENTRIES : ((1 << PTR_W) - 1);
  localparam logic [PTR_W-1:0] SAT_V = PTR_W'(SAT);

  spl_state_e state, state_next;

  // request latch and search window
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic [PTR_W-1:0]   end_q;
  logic [PTR_W-1:0]   lo, hi, mid;

  // pending result
  logic               res_found;
  logic [SLOT_W-1:0]  res_pos;
  logic [LABEL_W-1:0] res_label;
  logic [DEPTH_W-1:0] res_depth;

  // memories
  logic               row_we;
  logic [RAW-1:0]     row_raddr;
  logic [PTR_W-1:0]   row_rdata;
  logic               ent_we;
  logic [EAW-1:0]     ent_raddr;
  logic [EW-1:0]      ent_rdata;

  logic [COL_W-1:0]   ent_col;
  logic [LBW-1:0]     ent_label;
  logic [DEPTH_W-1:0] ent_depth;

  logic               accept;
  logic               in_range;
  logic               out_free;
  logic [PTR_W-1:0]   rd_sat;
  logic [PTR_W-1:0]   start_v;
  logic               window_ok;
  logic [PTR_W-1:0]   mid_first;
  logic               go_right;
  logic [PTR_W-1:0]   lo_n, hi_n, mid_n;
  logic               more;

  spl_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ROWS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (RAW'(req.row)),
    .wdata (req.row_end),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  spl_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (EAW'(req.entry_slot)),
    .wdata ({req.column, req.label_in[LBW-1:0], req.depth_in}),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign {ent_col, ent_label, ent_depth} = ent_rdata;

  assign accept   = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;
  assign in_range = (HEIGHT_W'(req.row) < regs.image_height)
                 && (32'(req.row) < MAX_ROWS)
                 && (WIDTH_W'(req.column) < regs.image_width);

  // datapath arithmetic
  always_comb begin
    rd_sat    = (row_rdata > SAT_V) ? SAT_V : row_rdata;
    start_v   = (row_q == '0) ? '0 : rd_sat;
    window_ok = start_v < end_q;
    mid_first = start_v + ((end_q - start_v) >> 1);
    go_right  = ent_col < col_q;
    lo_n      = go_right ? mid + PTR_W'(1) : lo;
    hi_n      = go_right ? hi : mid;
    more      = lo_n < hi_n;
    mid_n     = lo_n + ((hi_n - lo_n) >> 1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && req.operation == OP_LOOKUP) begin
          state_next = in_range ? S_ROW_END : S_RESULT;
        end
      end
      S_ROW_END:   state_next = S_ROW_START;
      S_ROW_START: state_next = window_ok ? S_SEARCH : S_RESULT;
      S_SEARCH:    state_next = more ? S_SEARCH : S_CHECK;
      S_CHECK:     state_next = S_RESULT;
      S_RESULT:    state_next = out_free ? S_IDLE : S_RESULT;
      default:     state_next = S_IDLE;
    endcase
  end

  // state outputs: handshake, memory ports
  always_comb begin
    req.ready = 1'b0;
    row_we    = 1'b0;
    ent_we    = 1'b0;
    row_raddr = RAW'(row_q - ROW_W'(1));
    ent_raddr = EAW'(mid_n);
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        row_raddr = RAW'(req.row);
        row_we    = req.valid && req.operation == OP_ROW_END
                 && (32'(req.row) < MAX_ROWS);
        ent_we    = req.valid && req.operation == OP_ENTRY
                 && (32'(req.entry_slot) < MAX_ENTRIES);
      end
      S_ROW_START: ent_raddr = EAW'(mid_first);
      S_SEARCH:    ent_raddr = more ? EAW'(mid_n) : EAW'(lo_n);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        row_q     <= req.row;
        col_q     <= req.column;
        res_found <= 1'b0;
        res_pos   <= '0;
        res_label <= regs.missing_label;
        res_depth <= regs.missing_depth;
      end
      S_ROW_END: end_q <= rd_sat;
      S_ROW_START: begin
        lo  <= start_v;
        hi  <= end_q;
        mid <= mid_first;
      end
      S_SEARCH: begin
        lo  <= lo_n;
        hi  <= hi_n;
        mid <= mid_n;
      end
      S_CHECK: begin
        if (lo < end_q && ent_col == col_q) begin
          res_found <= 1'b1;
          res_pos   <= SLOT_W'(lo);
          res_label <= LABEL_W'(ent_label);
          res_depth <= ent_depth;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_RESULT && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      rsp.found          <= res_found;
      rsp.entry_position <= res_pos;
      rsp.label_out      <= res_label;
      rsp.depth_out      <= res_depth;
    end
  end

  a_window_open: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> lo < hi)
    else $error("search window empty while searching");

  a_mid_inside: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> (lo <= mid && mid < hi && hi <= end_q))
    else $error("probe outside search window");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_RESULT)
    else $error("result raised outside result state");

  a_miss_position: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.found |-> rsp.entry_position == '0)
    else $error("miss reported with nonzero position");

endmodule

`default_nettype wire
